[design/rpc_tag_allocator_and_matcher_unit_assert.svh]
// Assertion macros used by the tag allocator datapath (rtam_dpath).
`ifndef RPC_TAG_ALLOCATOR_AND_MATCHER_UNIT_ASSERT_SVH
`define RPC_TAG_ALLOCATOR_AND_MATCHER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// pre holds -> post holds in the same cycle
`define RTAM_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rtam: assertion failed");
// pre holds -> post holds in the next cycle
`define RTAM_ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rtam: assertion failed");
// cond never holds
`define RTAM_ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rtam: assertion failed");
`else
`define RTAM_ASSERT_IMP(name, clk, rst_n, pre, post)
`define RTAM_ASSERT_NXT(name, clk, rst_n, pre, post)
`define RTAM_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

[design/rtam_pkg.sv]
package rtam_pkg;

    localparam int TAG_BITS      = 16;
    localparam int SPAN_BITS     = 9;
    localparam int STATUS_BITS   = 3;
    localparam int OP_BITS       = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [SPAN_BITS-1:0] SPAN_RESET = 9'd256;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_TAG  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAG_SPAN = 2'd1;

    typedef enum logic [OP_BITS-1:0] {
        OP_ALLOC   = 2'd0,
        OP_REPLY   = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_RANGE  = 3'd2,
        ST_NOWAIT = 3'd3,
        ST_FREE   = 3'd4
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic cfg_write;
        logic load;
        logic decode;
        logic check;
        logic scan;
        logic out_load;
    } rtam_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic in_range;
        logic alloc_ok;
        logic scan_hit;
        logic scan_empty;
    } rtam_stat_t;

endpackage

[design/rtam_ctrl.sv]
module rtam_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  rtam_pkg::rtam_stat_t   stat,
    output rtam_pkg::rtam_cmd_t    cmd
);
    import rtam_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_CHECK  = 5'b00100,
        S_SCAN   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        slot_free  = !out_valid_reg || !out_stall;
        case (state_reg)
            S_IDLE:
            begin
                cmd.cfg_write = cfg_valid;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                case (stat.op)
                    OP_ALLOC:
                        state_next = stat.alloc_ok ? S_SCAN : S_FINISH;
                    OP_REPLY, OP_RELEASE:
                        state_next = stat.in_range ? S_CHECK : S_FINISH;
                    default:
                        state_next = S_FINISH;
                endcase
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = S_FINISH;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_hit || stat.scan_empty)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // wait for the output register to be free or drained
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[design/rtam_dpath.sv]
`include "rpc_tag_allocator_and_matcher_unit_assert.svh"

module rtam_dpath #(
    parameter int TABLE_DEPTH = 256,
    parameter int OWNER_BITS  = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rtam_pkg::rtam_cmd_t                  cmd,
    output rtam_pkg::rtam_stat_t                 stat,
    input  logic [rtam_pkg::OP_BITS-1:0]         operation,
    input  logic [OWNER_BITS-1:0]                owner_id,
    input  logic [rtam_pkg::TAG_BITS-1:0]        tag_in,
    input  logic [rtam_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [rtam_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic [rtam_pkg::STATUS_BITS-1:0]     status,
    output logic [rtam_pkg::TAG_BITS-1:0]        tag_out,
    output logic [OWNER_BITS-1:0]                owner_out,
    output logic [$clog2(TABLE_DEPTH + 1)-1:0]   outstanding
);
    import rtam_pkg::*;

    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int SW  = $clog2(TABLE_DEPTH + 1);
    localparam int SW1 = SW + 1;
    localparam int CW  = (SW > TAG_BITS) ? SW : TAG_BITS;
    localparam int EW  = OWNER_BITS + 2;
    localparam logic [SW-1:0]  DEPTH_W = SW'(TABLE_DEPTH);
    localparam logic [SW1-1:0] DEPTH_X = SW1'(TABLE_DEPTH);

    // entry layout: {waiting, busy, owner}
    logic [EW-1:0] entry_mem [TABLE_DEPTH];
    logic [EW-1:0] rd_data_reg;
    logic [IW-1:0] rd_addr_reg;
    logic [IW-1:0] rd_addr;
    logic          mem_we;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic [TAG_BITS-1:0]   min_tag_reg,    min_tag_next;
    logic [SPAN_BITS-1:0]  tag_span_reg,   tag_span_next;
    logic [SW-1:0]         table_size_reg, table_size_next;
    logic [IW-1:0]         free_hint_reg,  free_hint_next;
    logic [SW-1:0]         busy_count_reg, busy_count_next;
    logic [SW-1:0]         fill_reg,       fill_next;
    logic                  probe_valid_reg, probe_valid_next;

    logic [IW-1:0]         issue_idx_reg,  issue_idx_next;
    logic [SW-1:0]         issue_cnt_reg,  issue_cnt_next;
    op_t                   op_reg,         op_next;
    logic [OWNER_BITS-1:0] owner_reg,      owner_next;
    logic [IW-1:0]         idx_reg,        idx_next;
    logic                  in_range_reg,   in_range_next;
    status_t               res_status_reg, res_status_next;
    logic [TAG_BITS-1:0]   res_tag_reg,    res_tag_next;
    logic [OWNER_BITS-1:0] res_owner_reg,  res_owner_next;
    status_t               status_reg,     status_next;
    logic [TAG_BITS-1:0]   tag_out_reg,    tag_out_next;
    logic [OWNER_BITS-1:0] owner_out_reg,  owner_out_next;
    logic [SW-1:0]         outstanding_reg, outstanding_next;

    logic [TAG_BITS-1:0]   idx_diff;
    logic [SW-1:0]         rd_addr_ext;
    logic                  ent_written;
    logic                  ent_busy;
    logic                  ent_waiting;
    logic [OWNER_BITS-1:0] ent_owner;
    logic                  size_full;
    logic                  can_grow;
    logic                  alloc_ok;
    logic [SW1-1:0]        doubled;
    logic [SW-1:0]         grown;
    logic [IW-1:0]         old_hint;
    logic [SW-1:0]         scan_size;
    logic [IW-1:0]         scan_hint;
    logic [IW-1:0]         scan_start;
    logic                  issue_more;
    logic                  issue_wrap;
    logic                  scan_hit_raw;
    logic                  scan_empty;
    logic                  hit;

    // entries at or above the fill mark were never written since reset: read as free
    assign idx_diff     = tag_in - min_tag_reg;
    assign rd_addr_ext  = SW'(rd_addr_reg);
    assign ent_written  = rd_addr_ext < fill_reg;
    assign ent_busy     = ent_written && rd_data_reg[OWNER_BITS];
    assign ent_waiting  = ent_written && rd_data_reg[OWNER_BITS+1];
    assign ent_owner    = rd_data_reg[OWNER_BITS-1:0];

    assign size_full = busy_count_reg >= table_size_reg;
    assign can_grow  = (CW'(table_size_reg) < CW'(tag_span_reg)) && (table_size_reg < DEPTH_W);
    assign alloc_ok  = !size_full || can_grow;
    assign doubled   = {table_size_reg, 1'b0};
    assign grown     = (table_size_reg == '0) ? SW'(1) :
                       ((doubled > DEPTH_X) ? DEPTH_W : doubled[SW-1:0]);
    assign old_hint  = table_size_reg[IW-1:0];
    assign scan_size  = size_full ? grown : table_size_reg;
    assign scan_hint  = size_full ? old_hint : free_hint_reg;
    assign scan_start = (SW'(scan_hint) < scan_size) ? scan_hint : '0;

    assign issue_more   = issue_cnt_reg < table_size_reg;
    assign issue_wrap   = (SW'(issue_idx_reg) + SW'(1)) == table_size_reg;
    assign scan_hit_raw = probe_valid_reg && !ent_busy;
    assign scan_empty   = !probe_valid_reg && !issue_more;
    assign hit          = cmd.scan && scan_hit_raw;

    assign rd_addr = cmd.scan ? issue_idx_reg : idx_reg;

    always_comb
    begin
        stat.op         = op_reg;
        stat.in_range   = in_range_reg;
        stat.alloc_ok   = alloc_ok;
        stat.scan_hit   = scan_hit_raw;
        stat.scan_empty = scan_empty;
    end

    always_comb
    begin
        min_tag_next     = min_tag_reg;
        tag_span_next    = tag_span_reg;
        table_size_next  = table_size_reg;
        free_hint_next   = free_hint_reg;
        busy_count_next  = busy_count_reg;
        fill_next        = fill_reg;
        probe_valid_next = probe_valid_reg;
        issue_idx_next   = issue_idx_reg;
        issue_cnt_next   = issue_cnt_reg;
        op_next          = op_reg;
        owner_next       = owner_reg;
        idx_next         = idx_reg;
        in_range_next    = in_range_reg;
        res_status_next  = res_status_reg;
        res_tag_next     = res_tag_reg;
        res_owner_next   = res_owner_reg;
        status_next      = status_reg;
        tag_out_next     = tag_out_reg;
        owner_out_next   = owner_out_reg;
        outstanding_next = outstanding_reg;
        mem_we           = 1'b0;
        wr_addr          = rd_addr_reg;
        wr_data          = rd_data_reg;

        if (cmd.cfg_write)
        begin
            case (cfg_index)
                CFG_MIN_TAG:  min_tag_next  = cfg_data[TAG_BITS-1:0];
                CFG_TAG_SPAN: tag_span_next = cfg_data[SPAN_BITS-1:0];
                default:      ;
            endcase
        end

        if (cmd.load)
        begin
            op_next         = op_t'(operation);
            owner_next      = owner_id;
            idx_next        = idx_diff[IW-1:0];
            in_range_next   = CW'(idx_diff) < CW'(table_size_reg);
            res_status_next = ST_OK;
            res_tag_next    = tag_in;
            res_owner_next  = '0;
        end

        if (cmd.decode)
        begin
            case (op_reg)
                OP_ALLOC:
                begin
                    res_tag_next = '0;
                    if (!alloc_ok)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        if (size_full)
                        begin
                            table_size_next = grown;
                            free_hint_next  = old_hint;
                        end
                        issue_idx_next   = scan_start;
                        issue_cnt_next   = '0;
                        probe_valid_next = 1'b0;
                    end
                end
                OP_REPLY, OP_RELEASE:
                begin
                    if (!in_range_reg)
                    begin
                        res_status_next = ST_RANGE;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.check)
        begin
            case (op_reg)
                OP_REPLY:
                begin
                    if (!ent_waiting)
                    begin
                        res_status_next = ST_NOWAIT;
                    end
                    else
                    begin
                        res_owner_next = ent_owner;
                        mem_we         = 1'b1;
                        wr_data        = {1'b0, ent_busy, ent_owner};
                    end
                end
                OP_RELEASE:
                begin
                    if (!ent_busy)
                    begin
                        res_status_next = ST_FREE;
                    end
                    else
                    begin
                        mem_we  = 1'b1;
                        wr_data = {2'b00, ent_owner};
                        if (busy_count_reg != '0)
                        begin
                            busy_count_next = busy_count_reg - SW'(1);
                        end
                        free_hint_next = rd_addr_reg;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.scan)
        begin
            // one probe issued per cycle, its data checked the cycle after
            if (issue_more)
            begin
                probe_valid_next = 1'b1;
                issue_cnt_next   = issue_cnt_reg + SW'(1);
                issue_idx_next   = issue_wrap ? '0 : (issue_idx_reg + IW'(1));
            end
            else
            begin
                probe_valid_next = 1'b0;
            end

            if (scan_hit_raw)
            begin
                mem_we          = 1'b1;
                wr_data         = {2'b11, owner_reg};
                busy_count_next = busy_count_reg + SW'(1);
                if (rd_addr_ext == fill_reg)
                begin
                    fill_next = fill_reg + SW'(1);
                end
                res_tag_next = min_tag_reg + TAG_BITS'(rd_addr_reg);
            end
            else if (scan_empty)
            begin
                res_status_next = ST_FULL;
            end
        end

        if (cmd.out_load)
        begin
            status_next      = res_status_reg;
            tag_out_next     = res_tag_reg;
            owner_out_next   = res_owner_reg;
            outstanding_next = busy_count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= entry_mem[rd_addr];
        rd_addr_reg <= rd_addr;
        if (mem_we)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_tag_reg     <= '0;
            tag_span_reg    <= SPAN_RESET;
            table_size_reg  <= '0;
            free_hint_reg   <= '0;
            busy_count_reg  <= '0;
            fill_reg        <= '0;
            probe_valid_reg <= 1'b0;
        end
        else
        begin
            min_tag_reg     <= min_tag_next;
            tag_span_reg    <= tag_span_next;
            table_size_reg  <= table_size_next;
            free_hint_reg   <= free_hint_next;
            busy_count_reg  <= busy_count_next;
            fill_reg        <= fill_next;
            probe_valid_reg <= probe_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_idx_reg   <= issue_idx_next;
        issue_cnt_reg   <= issue_cnt_next;
        op_reg          <= op_next;
        owner_reg       <= owner_next;
        idx_reg         <= idx_next;
        in_range_reg    <= in_range_next;
        res_status_reg  <= res_status_next;
        res_tag_reg     <= res_tag_next;
        res_owner_reg   <= res_owner_next;
        status_reg      <= status_next;
        tag_out_reg     <= tag_out_next;
        owner_out_reg   <= owner_out_next;
        outstanding_reg <= outstanding_next;
    end

    assign status      = status_reg;
    assign tag_out     = tag_out_reg;
    assign owner_out   = owner_out_reg;
    assign outstanding = outstanding_reg;

    // a free entry is always found at or below the fill mark
    `RTAM_ASSERT_IMP(a_hit_within_fill, clk, rst_n, hit, rd_addr_ext <= fill_reg)
    `RTAM_ASSERT_NXT(a_hit_counts_up, clk, rst_n, hit, busy_count_reg == $past(busy_count_reg) + 1'b1)
    `RTAM_ASSERT_NEVER(a_count_within_size, clk, rst_n, busy_count_reg > table_size_reg)
    `RTAM_ASSERT_NEVER(a_fill_within_size, clk, rst_n, fill_reg > table_size_reg)
    `RTAM_ASSERT_NEVER(a_scan_never_empty, clk, rst_n, cmd.scan && scan_empty)

endmodule

[design/rpc_tag_allocator_and_matcher_unit.sv]
// Transaction tag allocator and reply matcher. Each accepted item is one of:
// allocate (find a free table entry circularly from the free hint, mark it
// busy and waiting, store owner_id, return min_tag + index; the table in use
// grows 0 -> 1 -> 2x up to TABLE_DEPTH while full and below tag_span), reply
// match (check range and waiting mark, return the stored owner, clear waiting)
// or release (free the entry, point the hint at it). One result transfer per
// item. From input transfer to the result landing in the output register,
// an item goes from accept to decode, then to a check of the entry for a
// reply or release of an in-range tag or to the search for an allocate that
// is not refused as full, then to finish; an out-of-range tag, the unused
// code and an allocate refused as full go from decode straight to finish.
// The entry table is a single memory with a registered read, so the allocate
// search probes one entry per cycle; reply and release do a read-modify-write
// of that memory. Items are handled one at a time; the next input transfer is
// taken as soon as the result is in the output register, even if that result
// is still stalled. No clearing pass after reset: a fill mark treats entries
// never written since reset as free. Configuration writes are taken only while
// no item is in flight (cfg_ready is low otherwise).
module rpc_tag_allocator_and_matcher_unit #(
    parameter int TABLE_DEPTH = 256,
    parameter int OWNER_BITS  = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // request channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [rtam_pkg::OP_BITS-1:0]         operation,
    input  logic [OWNER_BITS-1:0]                owner_id,
    input  logic [rtam_pkg::TAG_BITS-1:0]        tag_in,

    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [rtam_pkg::STATUS_BITS-1:0]     status,
    output logic [rtam_pkg::TAG_BITS-1:0]        tag_out,
    output logic [OWNER_BITS-1:0]                owner_out,
    output logic [$clog2(TABLE_DEPTH + 1)-1:0]   outstanding,

    // configuration write channel: index 0 min_tag, index 1 tag_span
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rtam_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [rtam_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import rtam_pkg::*;

    rtam_cmd_t  cmd;
    rtam_stat_t stat;

    // sequencer: accept, decode, table read / search, finish into output register
    rtam_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // entry memory, table size, hint, counters, config and result registers
    rtam_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .OWNER_BITS  (OWNER_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .operation   (operation),
        .owner_id    (owner_id),
        .tag_in      (tag_in),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .status      (status),
        .tag_out     (tag_out),
        .owner_out   (owner_out),
        .outstanding (outstanding)
    );

endmodule
